// ===== hdl/smeu_pkg.sv =====
// Package: types, opcodes and constants of the stack machine execute unit.
`timescale 1ns / 1ps
package smeu_pkg;

    localparam int STACK_DEPTH_DEF  = 256;
    localparam int REG_COUNT_DEF    = 16;
    localparam int ADDRESS_BITS_DEF = 16;

    localparam int OP_NOP   = 0;
    localparam int OP_PUSH  = 1;
    localparam int OP_POP   = 2;
    localparam int OP_LOAD  = 3;
    localparam int OP_STORE = 4;
    localparam int OP_JUMP  = 5;
    localparam int OP_JZ    = 6;
    localparam int OP_JNZ   = 7;
    localparam int OP_ADD   = 8;
    localparam int OP_SUB   = 9;
    localparam int OP_MUL   = 10;
    localparam int OP_DIV   = 11;
    localparam int OP_PRINT = 12;

    typedef enum logic [2:0] {
        ST_RUN   = 3'd0,
        ST_HALT  = 3'd1,
        ST_OVER  = 3'd2,
        ST_UNDER = 3'd3,
        ST_DIVZ  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic [7:0]         kind;
        logic signed [31:0] immediate;
        logic [3:0]         reg_index;
        logic [15:0]        target;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        next_address;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic [2:0]         status;
    } out_item_t;

endpackage

// ===== hdl/smeu_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
`timescale 1ns / 1ps
module smeu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/smeu_div.sv =====
// Radix-2 restoring signed divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module smeu_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        busy,
    output logic [31:0] quot
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;
    logic [31:0] shifted;

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[30:0], q_reg[31]};
        trial     = {1'b0, shifted} - {1'b0, d_reg};
        if (start) begin
            rem_next  = '0;
            q_next    = num[31] ? (~num + 32'd1) : num;
            d_next    = den[31] ? (~den + 32'd1) : den;
            neg_next  = num[31] ^ den[31];
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // Shift in the next dividend bit and try a subtract
            if (!trial[32]) begin
                rem_next = trial[31:0];
                q_next   = {q_reg[30:0], 1'b1};
            end else begin
                rem_next = shifted;
                q_next   = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign quot = neg_reg ? (~q_reg + 32'd1) : q_reg;
endmodule

// ===== hdl/stack_machine_execute_unit.sv =====
// Top level of the stack machine execute unit.
`timescale 1ns / 1ps
// Executes one pre-decoded instruction per beat. The operand stack lives in a
// synchronous RAM that is read at the accepting edge; the data arrives in the
// following execute cycle and the result beat is offered from the next edge
// on; no new beat is taken while a result waits or an operation runs. Mul
// passes through a product register state, then a write-back state, and div
// runs 32 quotient steps in the bit-serial divider, a state to see it finish
// and a write-back. The entry below the top comes from a
// second RAM that mirrors every stack write, so both operands are read in the
// same cycle. A halt or fault latches the status until reset; after that
// every beat returns the held address.
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH  = smeu_pkg::STACK_DEPTH_DEF,
    parameter int REG_COUNT    = smeu_pkg::REG_COUNT_DEF,
    parameter int ADDRESS_BITS = smeu_pkg::ADDRESS_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  smeu_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output smeu_pkg::out_item_t m_data
);
    localparam int SPW = $clog2(STACK_DEPTH);
    localparam int DW  = $clog2(STACK_DEPTH + 1);
    localparam int RW  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    smeu_pkg::fsm_t    state_reg, state_next;
    smeu_pkg::in_item_t item_reg;
    smeu_pkg::status_t run_reg, run_next;
    logic [DW-1:0]           depth_reg, depth_next;
    logic [ADDRESS_BITS-1:0] pc_reg, pc_next;
    logic [31:0]             gregs_reg [REG_COUNT];
    smeu_pkg::out_item_t     out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;
    logic [31:0]             prod_reg;

    // Stack RAM ports
    logic           st_we;
    logic [SPW-1:0] st_waddr, st_raddr;
    logic [31:0]    st_wdata, st_rdata;
    logic [SPW-1:0] a_raddr;
    logic [31:0]    a_rdata;

    // Divider
    logic               div_start;
    logic               div_busy;
    logic [31:0]        quot;

    logic accept;
    logic [31:0] top, below, res;
    logic [ADDRESS_BITS-1:0] tgt;
    logic [7:0] k;
    logic [RW-1:0] ri;
    logic ri_ok;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == smeu_pkg::S_IDLE) && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Top-of-stack and next-below reads, addressed from the current stack depth
    assign st_raddr = SPW'(depth_reg - DW'(1));
    assign a_raddr  = SPW'(depth_reg - DW'(2));

    smeu_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );
    // Mirror copy for the second operand read
    smeu_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack_b (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(a_raddr), .rdata(a_rdata)
    );

    assign top   = st_rdata;
    assign below = a_rdata;
    assign k     = item_reg.kind;
    assign tgt   = ADDRESS_BITS'(item_reg.target);
    assign ri    = RW'(item_reg.reg_index);
    assign ri_ok = 32'(item_reg.reg_index) < REG_COUNT;

    assign div_start = (state_reg == smeu_pkg::S_READ) && (k == 8'(smeu_pkg::OP_DIV))
                       && (run_reg == smeu_pkg::ST_RUN) && (depth_reg >= DW'(2))
                       && (top != 32'd0);

    smeu_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(below), .den(top), .busy(div_busy), .quot(quot)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            smeu_pkg::S_IDLE: if (accept) state_next = smeu_pkg::S_READ;
            smeu_pkg::S_READ: begin
                if (div_start) state_next = smeu_pkg::S_DIV;
                else if (run_reg == smeu_pkg::ST_RUN && k == 8'(smeu_pkg::OP_MUL)
                         && depth_reg >= DW'(2)) state_next = smeu_pkg::S_MUL;
                else state_next = smeu_pkg::S_IDLE;
            end
            smeu_pkg::S_MUL: state_next = smeu_pkg::S_DONE;
            smeu_pkg::S_DIV: if (!div_busy) state_next = smeu_pkg::S_DONE;
            smeu_pkg::S_DONE: state_next = smeu_pkg::S_IDLE;
            default: state_next = smeu_pkg::S_IDLE;
        endcase
    end

    // Execute and write back
    always_comb begin
        logic full, fault;
        logic [ADDRESS_BITS-1:0] nxt;
        logic [31:0] ldv;
        smeu_pkg::status_t st;
        full  = depth_reg >= DW'(STACK_DEPTH);
        fault = 1'b0;
        st    = smeu_pkg::ST_RUN;
        nxt   = pc_reg;
        ldv   = ri_ok ? gregs_reg[ri] : 32'd0;
        res   = '0;
        st_we = 1'b0;
        st_waddr = SPW'(depth_reg);
        st_wdata = '0;
        depth_next = depth_reg;
        run_next   = run_reg;
        pc_next    = pc_reg;
        out_next   = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (state_reg == smeu_pkg::S_READ && !(state_next == smeu_pkg::S_MUL)
            && !div_start) begin
            out_next.print_valid = 1'b0;
            out_next.print_value = '0;
            if (run_reg != smeu_pkg::ST_RUN) begin
                st = run_reg;
            end else begin
                priority case (1'b1)
                    k == 8'(smeu_pkg::OP_NOP): nxt = pc_reg + ADDRESS_BITS'(1);
                    k == 8'(smeu_pkg::OP_PUSH) || k == 8'(smeu_pkg::OP_LOAD): begin
                        if (full) st = smeu_pkg::ST_OVER;
                        else begin
                            st_we = 1'b1;
                            st_wdata = (k == 8'(smeu_pkg::OP_PUSH)) ? item_reg.immediate : ldv;
                            depth_next = depth_reg + DW'(1);
                            nxt = pc_reg + ADDRESS_BITS'((k == 8'(smeu_pkg::OP_PUSH)) ? 5 : 2);
                        end
                    end
                    k == 8'(smeu_pkg::OP_POP) || k == 8'(smeu_pkg::OP_STORE)
                        || k == 8'(smeu_pkg::OP_PRINT): begin
                        if (depth_reg == '0) st = smeu_pkg::ST_UNDER;
                        else begin
                            depth_next = depth_reg - DW'(1);
                            nxt = pc_reg + ADDRESS_BITS'((k == 8'(smeu_pkg::OP_STORE)) ? 2 : 1);
                            if (k == 8'(smeu_pkg::OP_PRINT)) begin
                                out_next.print_valid = 1'b1;
                                out_next.print_value = top;
                            end
                        end
                    end
                    k == 8'(smeu_pkg::OP_JUMP): nxt = tgt;
                    k == 8'(smeu_pkg::OP_JZ) || k == 8'(smeu_pkg::OP_JNZ): begin
                        if (depth_reg == '0) st = smeu_pkg::ST_UNDER;
                        else if ((k == 8'(smeu_pkg::OP_JZ)) == (top == 32'd0)) nxt = tgt;
                        else nxt = pc_reg + ADDRESS_BITS'(3);
                    end
                    k == 8'(smeu_pkg::OP_ADD) || k == 8'(smeu_pkg::OP_SUB)
                        || k == 8'(smeu_pkg::OP_MUL) || k == 8'(smeu_pkg::OP_DIV): begin
                        if (depth_reg < DW'(2)) st = smeu_pkg::ST_UNDER;
                        else if (k == 8'(smeu_pkg::OP_DIV)) st = smeu_pkg::ST_DIVZ;
                        else begin
                            res = (k == 8'(smeu_pkg::OP_ADD)) ? below + top : below - top;
                            st_we = 1'b1;
                            st_waddr = SPW'(depth_reg - DW'(2));
                            st_wdata = res;
                            depth_next = depth_reg - DW'(1);
                            nxt = pc_reg + ADDRESS_BITS'(1);
                        end
                    end
                    default: st = smeu_pkg::ST_HALT;
                endcase
                fault = (st != smeu_pkg::ST_RUN);
                if (fault) nxt = pc_reg;
                run_next = st;
                pc_next  = nxt;
            end
            out_next.next_address = 16'(nxt);
            out_next.status = st;
            out_valid_next = 1'b1;
        end else if (state_reg == smeu_pkg::S_DONE) begin
            // Multi-cycle arithmetic retires here
            res = (k == 8'(smeu_pkg::OP_MUL)) ? prod_reg : quot;
            st_we = 1'b1;
            st_waddr = SPW'(depth_reg - DW'(2));
            st_wdata = res;
            depth_next = depth_reg - DW'(1);
            pc_next = pc_reg + ADDRESS_BITS'(1);
            out_next.next_address = 16'(pc_reg + ADDRESS_BITS'(1));
            out_next.print_valid = 1'b0;
            out_next.print_value = '0;
            out_next.status = smeu_pkg::ST_RUN;
            out_valid_next = 1'b1;
        end
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= smeu_pkg::S_IDLE;
            run_reg       <= smeu_pkg::ST_RUN;
            depth_reg     <= '0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) gregs_reg[i] <= '0;
        end else begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            depth_reg     <= depth_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == smeu_pkg::S_READ && run_reg == smeu_pkg::ST_RUN
                && k == 8'(smeu_pkg::OP_STORE) && depth_reg != '0 && ri_ok) begin
                gregs_reg[ri] <= top;
            end
        end
        if (accept) item_reg <= s_data;
        if (state_reg == smeu_pkg::S_READ) prod_reg <= below * top;
        out_reg <= out_next;
    end
endmodule

// ===== hdl/smeu_checker.sv =====
// Port-level checker for the stack machine execute unit, with its bind.
`timescale 1ns / 1ps
module smeu_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input smeu_pkg::out_item_t m_data
);
    logic       stopped_reg;
    logic [2:0] held_status_reg;

    // Remember the first stopped status handed out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stopped_reg     <= 1'b0;
            held_status_reg <= '0;
        end else if (m_valid && m_ready && !stopped_reg
                     && m_data.status != smeu_pkg::ST_RUN) begin
            stopped_reg     <= 1'b1;
            held_status_reg <= m_data.status;
        end
    end

    // A stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // No input taken while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted with result pending");

    // Print only while running
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.print_valid |-> m_data.status == smeu_pkg::ST_RUN)
        else $error("print with nonzero status");

    // A stopped machine keeps reporting the same status and never prints
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && stopped_reg |-> m_data.status == held_status_reg && !m_data.print_valid)
        else $error("stopped status changed");
endmodule

bind stack_machine_execute_unit smeu_checker u_smeu_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

// ===== test/smeu_result_checker.sv =====
// Result checker: predicts each instruction's outcome and compares result beats.
`timescale 1ns / 1ps
module smeu_result_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  smeu_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  smeu_pkg::out_item_t m_data,
    output int                  mismatch_count,
    output int                  results_checked,
    output int                  results_pending
);
    localparam int DEPTH = smeu_pkg::STACK_DEPTH_DEF;
    localparam int NREGS = smeu_pkg::REG_COUNT_DEF;

    // Shadow machine state
    logic [31:0]       shadow_stack [DEPTH];
    logic [31:0]       shadow_regs [NREGS];
    int unsigned       shadow_depth;
    logic [15:0]       shadow_pc;
    smeu_pkg::status_t shadow_status;

    smeu_pkg::out_item_t expected_results [$];

    initial begin
        mismatch_count  = 0;
        results_checked = 0;
        results_pending = 0;
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task automatic execute_instruction(input smeu_pkg::in_item_t it);
        smeu_pkg::out_item_t res;
        logic [31:0]         a;
        logic [31:0]         b;
        logic [31:0]         r;
        logic [15:0]         nxt;
        smeu_pkg::status_t   st;
        longint              q;
        res = '0;
        nxt = shadow_pc;
        st  = smeu_pkg::ST_RUN;
        r   = '0;
        if (shadow_status != smeu_pkg::ST_RUN) begin
            st = shadow_status;
        end else begin
            case (int'(it.kind))
                smeu_pkg::OP_NOP: nxt = shadow_pc + 16'd1;
                smeu_pkg::OP_PUSH, smeu_pkg::OP_LOAD: begin
                    if (shadow_depth >= DEPTH) begin
                        st = smeu_pkg::ST_OVER;
                    end else begin
                        if (int'(it.kind) == smeu_pkg::OP_PUSH) begin
                            r   = it.immediate;
                            nxt = shadow_pc + 16'd5;
                        end else begin
                            r   = (int'(it.reg_index) < NREGS) ? shadow_regs[it.reg_index] : '0;
                            nxt = shadow_pc + 16'd2;
                        end
                        shadow_stack[shadow_depth] = r;
                        shadow_depth++;
                    end
                end
                smeu_pkg::OP_POP, smeu_pkg::OP_STORE, smeu_pkg::OP_PRINT: begin
                    if (shadow_depth == 0) begin
                        st = smeu_pkg::ST_UNDER;
                    end else begin
                        shadow_depth--;
                        r = shadow_stack[shadow_depth];
                        if (int'(it.kind) == smeu_pkg::OP_POP) begin
                            nxt = shadow_pc + 16'd1;
                        end else if (int'(it.kind) == smeu_pkg::OP_STORE) begin
                            if (int'(it.reg_index) < NREGS) shadow_regs[it.reg_index] = r;
                            nxt = shadow_pc + 16'd2;
                        end else begin
                            res.print_valid = 1'b1;
                            res.print_value = r;
                            nxt = shadow_pc + 16'd1;
                        end
                    end
                end
                smeu_pkg::OP_JUMP: nxt = it.target;
                smeu_pkg::OP_JZ, smeu_pkg::OP_JNZ: begin
                    if (shadow_depth == 0) begin
                        st = smeu_pkg::ST_UNDER;
                    end else begin
                        r = shadow_stack[shadow_depth - 1];
                        if ((int'(it.kind) == smeu_pkg::OP_JZ) == (r == 0)) nxt = it.target;
                        else nxt = shadow_pc + 16'd3;
                    end
                end
                smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV: begin
                    if (shadow_depth < 2) begin
                        st = smeu_pkg::ST_UNDER;
                    end else begin
                        b = shadow_stack[shadow_depth - 1];
                        a = shadow_stack[shadow_depth - 2];
                        if (int'(it.kind) == smeu_pkg::OP_ADD) r = a + b;
                        else if (int'(it.kind) == smeu_pkg::OP_SUB) r = a - b;
                        else if (int'(it.kind) == smeu_pkg::OP_MUL) r = a * b;
                        else if (b == 0) st = smeu_pkg::ST_DIVZ;
                        else begin
                            // 64-bit quotient so min / -1 wraps back to min
                            q = longint'($signed(a)) / longint'($signed(b));
                            r = q[31:0];
                        end
                        if (st == smeu_pkg::ST_RUN) begin
                            shadow_depth--;
                            shadow_stack[shadow_depth - 1] = r;
                            nxt = shadow_pc + 16'd1;
                        end
                    end
                end
                default: st = smeu_pkg::ST_HALT;
            endcase
            if (st != smeu_pkg::ST_RUN) nxt = shadow_pc;
            shadow_pc     = nxt;
            shadow_status = st;
        end
        res.next_address = nxt;
        res.status       = st;
        expected_results.push_back(res);
    endtask

    // Watch both channels on each rising edge
    always @(posedge aclk) begin
        smeu_pkg::out_item_t want;
        if (!aresetn) begin
            for (int i = 0; i < NREGS; i++) shadow_regs[i] = '0;
            shadow_depth  = 0;
            shadow_pc     = '0;
            shadow_status = smeu_pkg::ST_RUN;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch("result beat with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (m_data.next_address !== want.next_address)
                        flag_mismatch($sformatf("next_address got %h want %h",
                                                m_data.next_address, want.next_address));
                    if (m_data.print_valid !== want.print_valid)
                        flag_mismatch($sformatf("print_valid got %b want %b",
                                                m_data.print_valid, want.print_valid));
                    if (m_data.print_value !== want.print_value)
                        flag_mismatch($sformatf("print_value got %h want %h",
                                                m_data.print_value, want.print_value));
                    if (m_data.status !== want.status)
                        flag_mismatch($sformatf("status got %0d want %0d",
                                                m_data.status, want.status));
                end
            end
            if (s_valid && s_ready) execute_instruction(s_data);
        end
        results_pending = expected_results.size();
    end

endmodule

// ===== test/testbench.sv =====
// Testbench top: clock, reset, instruction stimulus and the final verdict.
`timescale 1ns / 1ps
module testbench;
    localparam int DEPTH = smeu_pkg::STACK_DEPTH_DEF;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    smeu_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    smeu_pkg::out_item_t m_data;

    int mismatch_count;
    int results_checked;
    int results_pending;

    // Stimulus-side tracking, only to steer clear of early faults
    int unsigned prog_depth;
    bit          top_nonzero;
    int          beats_sent;
    int          terminal_case;
    bit          burst_mode;

    stack_machine_execute_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    smeu_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatch_count),
        .results_checked (results_checked),
        .results_pending (results_pending)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        burst_mode = 1'b0;
    end

    // Result side: random back-pressure, one long hold-off, one idle-free stretch
    initial begin
        int cyc;
        int hold_left;
        cyc       = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc == 3000) hold_left = 400;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (cyc > 6000 && cyc < 9000) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 29);
            end
        end
    end

    // Offer one beat and hold it until taken, then maybe idle
    task automatic send_instruction(input smeu_pkg::in_item_t it);
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        if (!burst_mode && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    function automatic smeu_pkg::in_item_t make_op(input int op, input logic [31:0] imm,
                                                   input logic [3:0] ri,
                                                   input logic [15:0] tgt);
        smeu_pkg::in_item_t it;
        it.kind      = op[7:0];
        it.immediate = imm;
        it.reg_index = ri;
        it.target    = tgt;
        return it;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(3))
            0: return $urandom_range(15);
            1: return -$urandom_range(15);
            2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Pick a legal random instruction and track the stack depth it leaves
    task automatic send_random_instruction();
        smeu_pkg::in_item_t it;
        int                 roll;
        int                 op;
        logic [31:0]        imm;
        roll = $urandom_range(99);
        imm  = random_word();
        if      (roll < 22) op = smeu_pkg::OP_PUSH;
        else if (roll < 30) op = smeu_pkg::OP_LOAD;
        else if (roll < 38) op = smeu_pkg::OP_POP;
        else if (roll < 44) op = smeu_pkg::OP_STORE;
        else if (roll < 50) op = smeu_pkg::OP_PRINT;
        else if (roll < 56) op = smeu_pkg::OP_JZ;
        else if (roll < 62) op = smeu_pkg::OP_JNZ;
        else if (roll < 66) op = smeu_pkg::OP_JUMP;
        else if (roll < 70) op = smeu_pkg::OP_NOP;
        else if (roll < 78) op = smeu_pkg::OP_ADD;
        else if (roll < 84) op = smeu_pkg::OP_SUB;
        else if (roll < 90) op = smeu_pkg::OP_MUL;
        else op = smeu_pkg::OP_DIV;
        // a divide needs a known nonzero divisor: push one first
        if (op == smeu_pkg::OP_DIV && !top_nonzero) op = smeu_pkg::OP_PUSH;
        if ((op == smeu_pkg::OP_ADD || op == smeu_pkg::OP_SUB || op == smeu_pkg::OP_MUL
             || op == smeu_pkg::OP_DIV) && prog_depth < 2)
            op = smeu_pkg::OP_PUSH;
        if ((op == smeu_pkg::OP_POP || op == smeu_pkg::OP_STORE || op == smeu_pkg::OP_PRINT
             || op == smeu_pkg::OP_JZ || op == smeu_pkg::OP_JNZ) && prog_depth == 0)
            op = smeu_pkg::OP_PUSH;
        if ((op == smeu_pkg::OP_PUSH || op == smeu_pkg::OP_LOAD) && prog_depth >= DEPTH)
            op = smeu_pkg::OP_POP;
        if (op == smeu_pkg::OP_PUSH && imm == 0 && $urandom_range(1)) imm = 32'd1;
        it = make_op(op, imm, 4'($urandom), 16'($urandom));
        case (op)
            smeu_pkg::OP_PUSH, smeu_pkg::OP_LOAD: prog_depth++;
            smeu_pkg::OP_POP, smeu_pkg::OP_STORE, smeu_pkg::OP_PRINT, smeu_pkg::OP_ADD,
            smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV: prog_depth--;
            default: ;
        endcase
        top_nonzero = (op == smeu_pkg::OP_PUSH && imm != 0);
        send_instruction(it);
    endtask

    initial begin
        smeu_pkg::in_item_t it;
        beats_sent  = 0;
        prog_depth  = 0;
        top_nonzero = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: wrapping add, min / -1, truncating divide, each opcode
        send_instruction(make_op(smeu_pkg::OP_PUSH, 32'h7FFF_FFFF, 4'd0, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_PUSH, 32'd1, 4'd0, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_ADD, 32'd0, 4'd0, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_PUSH, 32'h8000_0000, 4'd0, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_PUSH, 32'hFFFF_FFFF, 4'd0, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_DIV, 32'd0, 4'd0, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_PUSH, 32'd7, 4'd0, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_PUSH, -32'sd2, 4'd0, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_DIV, 32'd0, 4'd0, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_PUSH, 32'd3, 4'd0, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_SUB, 32'd0, 4'd0, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_PUSH, 32'h0001_0001, 4'd0, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_MUL, 32'd0, 4'd0, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_STORE, 32'd0, 4'd15, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_LOAD, 32'd0, 4'd15, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_LOAD, 32'd0, 4'd0, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_JZ, 32'd0, 4'd0, 16'hFFFF));
        send_instruction(make_op(smeu_pkg::OP_JNZ, 32'd0, 4'd0, 16'h0000));
        send_instruction(make_op(smeu_pkg::OP_JUMP, 32'd0, 4'd0, 16'hFFFF));
        send_instruction(make_op(smeu_pkg::OP_NOP, 32'd0, 4'd0, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_POP, 32'd0, 4'd0, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_PRINT, 32'd0, 4'd0, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_PRINT, 32'd0, 4'd0, 16'd0));
        send_instruction(make_op(smeu_pkg::OP_PRINT, 32'd0, 4'd0, 16'd0));

        // Random legal programs with a burst, a deep climb and a full drain
        for (int n = 0; n < 2000; n++) begin
            burst_mode = (n >= 1000 && n < 1300);
            if (n == 600) begin
                while (prog_depth < DEPTH - 1) begin
                    send_instruction(make_op(smeu_pkg::OP_PUSH, random_word(), 4'd0, 16'd0));
                    prog_depth++;
                end
                top_nonzero = 1'b0;
            end
            if (n == 1500) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (results_pending != 0) @(posedge aclk);
            end
            send_random_instruction();
        end
        burst_mode = 1'b0;

        // One terminal event, then the machine must hold its state
        terminal_case = $urandom_range(3);
        case (terminal_case)
            0: send_instruction(make_op(int'($urandom_range(13, 255)), 32'd0, 4'd0, 16'd0));
            1: begin
                while (prog_depth > 0) begin
                    send_instruction(make_op(smeu_pkg::OP_POP, 32'd0, 4'd0, 16'd0));
                    prog_depth--;
                end
                send_instruction(make_op(smeu_pkg::OP_POP, 32'd0, 4'd0, 16'd0));
            end
            2: begin
                send_instruction(make_op(smeu_pkg::OP_PUSH, 32'd5, 4'd0, 16'd0));
                send_instruction(make_op(smeu_pkg::OP_PUSH, 32'd0, 4'd0, 16'd0));
                send_instruction(make_op(smeu_pkg::OP_DIV, 32'd0, 4'd0, 16'd0));
            end
            default: begin
                while (prog_depth < DEPTH) begin
                    send_instruction(make_op(smeu_pkg::OP_PUSH, random_word(), 4'd0, 16'd0));
                    prog_depth++;
                end
                send_instruction(make_op(smeu_pkg::OP_PUSH, 32'd1, 4'd0, 16'd0));
            end
        endcase
        for (int n = 0; n < 30; n++) begin
            it = make_op(int'($urandom_range(255)), $urandom, 4'($urandom), 16'($urandom));
            it.kind = (n == 0) ? 8'hFF : (n == 1) ? 8'h00 : 8'($urandom);
            send_instruction(it);
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("Ran %0d instructions, %0d results checked, terminal event kind %0d.",
                 beats_sent, results_checked, terminal_case);
        $display("Covered every opcode, stack depths up to full, stalls and drains.");
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("stack_machine_execute_unit verification clean");
        end else begin
            $display("stack_machine_execute_unit verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("stack_machine_execute_unit verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/smeu_pkg.sv
hdl/smeu_ram.sv
hdl/smeu_div.sv
hdl/stack_machine_execute_unit.sv
hdl/smeu_checker.sv
test/smeu_result_checker.sv
test/testbench.sv
